// File: hw/rtl/crp_pkg.sv
package crp_pkg;

   // pseudo palette length, fixed for every depth but 8 bpp
   localparam int unsigned PSEUDO_DEPTH = 16;

   localparam int unsigned COLOR_W = 16;
   localparam int unsigned DAC_W   = 6;
   localparam int unsigned PACK_W  = 32;
   localparam int unsigned SHIFT_W = 5;
   localparam int unsigned DEPTH_W = 3;
   localparam int unsigned CSR_W   = 2;

   // depth mode codes
   localparam logic [DEPTH_W-1:0] DEPTH_8BPP  = 3'd0;
   localparam logic [DEPTH_W-1:0] DEPTH_15BPP = 3'd1;
   localparam logic [DEPTH_W-1:0] DEPTH_16BPP = 3'd2;
   localparam logic [DEPTH_W-1:0] DEPTH_24BPP = 3'd3;
   localparam logic [DEPTH_W-1:0] DEPTH_32BPP = 3'd4;

   // register indexes
   localparam logic [CSR_W-1:0] CSR_DEPTH_MODE  = 2'd0;
   localparam logic [CSR_W-1:0] CSR_RED_SHIFT   = 2'd1;
   localparam logic [CSR_W-1:0] CSR_GREEN_SHIFT = 2'd2;
   localparam logic [CSR_W-1:0] CSR_BLUE_SHIFT  = 2'd3;

   // red shift that selects 1:5:5:5 packing
   localparam logic [SHIFT_W-1:0] SHIFT_555 = 5'd10;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_READ  = 1'b1;

   typedef struct packed {
      logic [DEPTH_W-1:0] depth_mode;
      logic [SHIFT_W-1:0] red_shift;
      logic [SHIFT_W-1:0] green_shift;
      logic [SHIFT_W-1:0] blue_shift;
   } crp_cfg_type;

   typedef struct packed {
      logic               is_read;
      logic               bad;
      logic               hit;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } crp_stage_type;

   typedef struct packed {
      logic               bad_index;
      logic [COLOR_W-1:0] red_out;
      logic [COLOR_W-1:0] green_out;
      logic [COLOR_W-1:0] blue_out;
      logic               packed_valid;
      logic [PACK_W-1:0]  packed_word;
      logic               dac_valid;
      logic [DAC_W-1:0]   dac_red;
      logic [DAC_W-1:0]   dac_green;
      logic [DAC_W-1:0]   dac_blue;
   } crp_result_type;

endpackage

// File: hw/rtl/crp_req_if.sv
interface crp_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [7:0]  reg_index;
   logic [15:0] red_in;
   logic [15:0] green_in;
   logic [15:0] blue_in;

   modport source (output valid, action, reg_index, red_in, green_in, blue_in,
                   input ready);
   modport sink (input valid, action, reg_index, red_in, green_in, blue_in,
                 output ready);
endinterface

// File: hw/rtl/crp_rsp_if.sv
interface crp_rsp_if;
   logic        valid;
   logic        ready;
   logic        bad_index;
   logic [15:0] red_out;
   logic [15:0] green_out;
   logic [15:0] blue_out;
   logic        packed_valid;
   logic [31:0] packed_word;
   logic        dac_valid;
   logic [5:0]  dac_red;
   logic [5:0]  dac_green;
   logic [5:0]  dac_blue;

   modport source (output valid, bad_index, red_out, green_out, blue_out,
                   packed_valid, packed_word, dac_valid, dac_red, dac_green,
                   dac_blue,
                   input ready);
   modport sink (input valid, bad_index, red_out, green_out, blue_out,
                 packed_valid, packed_word, dac_valid, dac_red, dac_green,
                 dac_blue,
                 output ready);
endinterface

// File: hw/rtl/crp_ram.sv
module crp_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/crp_pack.sv
module crp_pack
   import crp_pkg::*;
(
   input  crp_cfg_type                cfg,
   input  crp_stage_type              stage,
   input  logic [3*COLOR_W-1:0]       rd_data,
   output crp_result_type             result
);
   logic [PACK_W-1:0] hi_word;
   logic [PACK_W-1:0] true_word;

   always_comb begin
      if (cfg.red_shift == SHIFT_555) begin
         hi_word = {17'd0, stage.red[15:11], stage.green[15:11], stage.blue[15:11]};
      end else begin
         hi_word = {16'd0, stage.red[15:11], stage.green[15:10], stage.blue[15:11]};
      end
      // bits past the top are dropped by the shift
      true_word = (PACK_W'(stage.red[15:8])   << cfg.red_shift)
                | (PACK_W'(stage.green[15:8]) << cfg.green_shift)
                | (PACK_W'(stage.blue[15:8])  << cfg.blue_shift);
   end

   always_comb begin
      result = '0;
      if (stage.bad) begin
         result.bad_index = 1'b1;
      end else if (stage.is_read) begin
         // never written entries read as zero
         if (stage.hit) begin
            result.red_out   = rd_data[3*COLOR_W-1:2*COLOR_W];
            result.green_out = rd_data[2*COLOR_W-1:COLOR_W];
            result.blue_out  = rd_data[COLOR_W-1:0];
         end
      end else begin
         unique case (cfg.depth_mode)
            DEPTH_8BPP: begin
               result.dac_valid = 1'b1;
               result.dac_red   = stage.red[15:10];
               result.dac_green = stage.green[15:10];
               result.dac_blue  = stage.blue[15:10];
            end
            DEPTH_15BPP, DEPTH_16BPP: begin
               result.packed_valid = 1'b1;
               result.packed_word  = hi_word;
            end
            DEPTH_24BPP, DEPTH_32BPP: begin
               result.packed_valid = 1'b1;
               result.packed_word  = true_word;
            end
            default: begin
               // unused depth codes only update the palette
               result.packed_valid = 1'b0;
            end
         endcase
      end
   end
endmodule

// File: hw/rtl/color_register_packer.sv
// channel   | direction | transfer when
// ----------+-----------+------------------------------
// req_bus   | in        | req_bus.valid & req_bus.ready
// rsp_bus   | out       | rsp_bus.valid & rsp_bus.ready
// csr_*     | in        | csr_wr_en (no handshake)
//
// one item per cycle sustained while results are taken; each item goes through
// the palette RAM read at transfer, then packing into the result register.
// the palette RAM's single read port per cycle sets that rate.
// reset clears the config registers and the per-entry valid bits at once,
// so no clearing pass is needed and never written entries read as zero.
// a stalled result holds the pipe; req_bus.ready drops only when both stages are full.
module color_register_packer
   import crp_pkg::*;
#(
   parameter int unsigned PALETTE_DEPTH = 256
) (
   input  logic                clock,
   input  logic                reset,
   crp_req_if.sink             req_bus,
   crp_rsp_if.source           rsp_bus,
   input  logic                csr_wr_en,
   input  logic [CSR_W-1:0]    csr_index,
   input  logic [SHIFT_W-1:0]  csr_wdata
);
   localparam int unsigned ADDR_W = $clog2(PALETTE_DEPTH);

   crp_cfg_type        cfg_ff;
   logic [PALETTE_DEPTH-1:0] written_ff;

   logic               s1_valid_ff;
   crp_stage_type      s1_ff;
   crp_stage_type      s1_in;
   logic               out_valid_ff;
   crp_result_type     out_ff;
   crp_result_type     out_in;

   logic               req_take;
   logic               s1_move;
   logic               bad;
   logic               wr_en;
   logic [ADDR_W-1:0]  addr;
   logic [3*COLOR_W-1:0] rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DEPTH_MODE:  cfg_ff.depth_mode  <= csr_wdata[DEPTH_W-1:0];
            CSR_RED_SHIFT:   cfg_ff.red_shift   <= csr_wdata;
            CSR_GREEN_SHIFT: cfg_ff.green_shift <= csr_wdata;
            CSR_BLUE_SHIFT:  cfg_ff.blue_shift  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign s1_move  = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_move;
   assign req_take = req_bus.valid && req_bus.ready;

   always_comb begin
      if (cfg_ff.depth_mode == DEPTH_8BPP) begin
         bad = {1'b0, req_bus.reg_index} >= 9'(PALETTE_DEPTH);
      end else begin
         bad = ({1'b0, req_bus.reg_index} >= 9'(PSEUDO_DEPTH))
            || ({1'b0, req_bus.reg_index} >= 9'(PALETTE_DEPTH));
      end
   end

   assign addr  = req_bus.reg_index[ADDR_W-1:0];
   assign wr_en = req_take && (req_bus.action == ACTION_WRITE) && !bad;

   always_comb begin
      s1_in.is_read = (req_bus.action == ACTION_READ);
      s1_in.bad     = bad;
      s1_in.hit     = written_ff[addr];
      s1_in.red     = req_bus.red_in;
      s1_in.green   = req_bus.green_in;
      s1_in.blue    = req_bus.blue_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[addr] <= 1'b1;
      end
   end

   crp_ram #(
      .WIDTH (3*COLOR_W),
      .DEPTH (PALETTE_DEPTH)
   ) palette_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data ({req_bus.red_in, req_bus.green_in, req_bus.blue_in}),
      .rd_en   (req_take),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ff <= s1_in;
      end
   end

   crp_pack packer (
      .cfg     (cfg_ff),
      .stage   (s1_ff),
      .rd_data (rd_data),
      .result  (out_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_move) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_ff <= out_in;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.bad_index    = out_ff.bad_index;
   assign rsp_bus.red_out      = out_ff.red_out;
   assign rsp_bus.green_out    = out_ff.green_out;
   assign rsp_bus.blue_out     = out_ff.blue_out;
   assign rsp_bus.packed_valid = out_ff.packed_valid;
   assign rsp_bus.packed_word  = out_ff.packed_word;
   assign rsp_bus.dac_valid    = out_ff.dac_valid;
   assign rsp_bus.dac_red      = out_ff.dac_red;
   assign rsp_bus.dac_green    = out_ff.dac_green;
   assign rsp_bus.dac_blue     = out_ff.dac_blue;
endmodule
